// ===== rtl/lph_pkg.sv =====
// ============================================================================
// Linear probe hash table package
// Shared types, sizes and codes for the hash table front end, queue and engine.
// ============================================================================
package lph_pkg;

	// Number of slots in the table.
	localparam int SLOTS = 64;

	// Slot index width, and width of the running remainder of hash mod SLOTS.
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int REM_W = $clog2(SLOTS) + 1;

	// The hash is reduced a byte per cycle.
	localparam int HASH_W     = 32;
	localparam int STEP_BITS  = 8;
	localparam int HASH_STEPS = HASH_W / STEP_BITS;
	localparam int STEP_CNT_W = $clog2(HASH_STEPS + 1);

	// Depth of the queue between the front end and the engine.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Command codes.
	localparam logic [1:0] CMD_GET = 2'd0;
	localparam logic [1:0] CMD_PUT = 2'd1;
	localparam logic [1:0] CMD_DEL = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Slot state codes.
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_USED  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key_id;
		logic [31:0] key_hash;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_value;
	} res_t;

	// A request after classification, with its home slot worked out.
	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] key_id;
		logic [63:0] value;
		idx_t        home;
	} job_t;

	// One entry of the slot state and key store.
	typedef struct packed {
		logic [1:0]  state;
		logic [31:0] key;
	} kent_t;

endpackage

// ===== rtl/lph_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module lph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lph_front.sv =====
// ============================================================================
// Hash table front end
// Accepts requests and reduces the hash to a home slot, one byte per cycle.
// ============================================================================
module lph_front
	import lph_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic job_push,
	input  logic job_full,
	output job_t job
);

	logic                  busy_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0]      rem_q;
	logic [HASH_W-1:0]     hash_q;
	logic [1:0]            cmd_q;
	logic [31:0]           key_q;
	logic [63:0]           value_q;
	logic                  done;
	logic                  accept;

	// Folds eight more hash bits into the remainder modulo SLOTS.
	function automatic logic [REM_W-1:0] step8(input logic [REM_W-1:0] rem_in,
			input logic [STEP_BITS-1:0] bits);
		logic [REM_W-1:0] r;
		r = rem_in;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			r = (r << 1) | REM_W'(bits[i]);
			if (r >= REM_W'(SLOTS)) begin
				r = r - REM_W'(SLOTS);
			end
		end
		return r;
	endfunction

	assign done     = busy_q && (cnt_q == STEP_CNT_W'(HASH_STEPS));
	assign job_push = done && !job_full;
	assign full     = busy_q && !job_push;
	assign accept   = push && !full;

	assign job.command = cmd_q;
	assign job.key_id  = key_q;
	assign job.value   = value_q;
	assign job.home    = rem_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_CNT_W'(1);
			end else if (job_push) begin
				busy_q <= 1'b0;
			end else if (busy_q && !done) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= request.command;
			key_q   <= request.key_id;
			value_q <= request.value;
			rem_q   <= step8('0, request.key_hash[HASH_W-1 -: STEP_BITS]);
			hash_q  <= request.key_hash << STEP_BITS;
		end else if (busy_q && !done) begin
			rem_q  <= step8(rem_q, hash_q[HASH_W-1 -: STEP_BITS]);
			hash_q <= hash_q << STEP_BITS;
		end
	end

endmodule

// ===== rtl/lph_queue.sv =====
// ============================================================================
// Job queue
// Short queue of classified requests between the front end and the engine.
// ============================================================================
module lph_queue
	import lph_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  job_t wdata,
	input  logic pop,
	output logic empty,
	output job_t rdata
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/lph_engine.sv =====
// ============================================================================
// Hash table engine
// Probes the slot stores one slot per cycle and carries out get, put and delete.
// ============================================================================
module lph_engine
	import lph_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  job_t q_job,
	output logic empty,
	input  logic pop,
	output res_t response
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_GETV
	} state_t;

	state_t     state_q;
	job_t       job_q;
	idx_t       idx_q;
	idx_t       n_q;
	logic       tomb_seen_q;
	idx_t       tomb_idx_q;
	logic       res_valid_q;
	res_t       res_q;
	logic [SLOTS-1:0] vld_q;
	logic       vld_rd_q;

	kent_t      ent;
	logic [$bits(kent_t)-1:0] kram_rdata;
	logic [63:0] vram_rdata;
	logic [1:0] slot_st;
	logic       is_empty;
	logic       is_used;
	logic       is_tomb;
	logic       hit;
	logic       last;
	logic       tomb_seen_n;
	idx_t       tomb_idx_n;
	idx_t       free_idx;
	logic       has_free;
	logic       finish;
	idx_t       next_idx;
	logic       res_free;
	logic       res_load;
	logic       start;
	logic       known_cmd;
	idx_t       rd_addr;
	logic       kram_we;
	idx_t       kram_waddr;
	kent_t      kram_wdata;
	logic       vram_we;
	idx_t       vram_waddr;
	logic       set_vld;
	logic [1:0] probe_status;

	lph_ram #(
		.WIDTH ($bits(kent_t)),
		.DEPTH (SLOTS)
	) u_kram (
		.clk   (clk),
		.we    (kram_we),
		.waddr (kram_waddr),
		.wdata (kram_wdata),
		.raddr (rd_addr),
		.rdata (kram_rdata)
	);

	lph_ram #(
		.WIDTH (64),
		.DEPTH (SLOTS)
	) u_vram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (job_q.value),
		.raddr (idx_q),
		.rdata (vram_rdata)
	);

	assign empty    = !res_valid_q;
	assign response = res_q;
	assign res_free = !res_valid_q || pop;
	assign start    = (state_q == S_IDLE) && !q_empty && res_free;
	assign q_pop    = start;
	assign known_cmd = (q_job.command == CMD_GET) || (q_job.command == CMD_PUT) ||
		(q_job.command == CMD_DEL);

	// A result item is loaded for an unused command at once, at the end of a
	// probe unless a get hit, and after the value fetch of a get that hit.
	assign res_load = (start && !known_cmd) || (state_q == S_GETV) ||
		((state_q == S_PROBE) && finish && !((job_q.command == CMD_GET) && hit));

	always_comb begin
		ent         = kent_t'(kram_rdata);
		slot_st     = vld_rd_q ? ent.state : SLOT_EMPTY;
		is_empty    = (slot_st == SLOT_EMPTY);
		is_used     = (slot_st == SLOT_USED);
		is_tomb     = !is_empty && !is_used;
		hit         = is_used && (ent.key == job_q.key_id);
		last        = (n_q == IDX_W'(SLOTS - 1));
		tomb_seen_n = tomb_seen_q || is_tomb;
		tomb_idx_n  = tomb_seen_q ? tomb_idx_q : idx_q;
		free_idx    = tomb_seen_n ? tomb_idx_n : idx_q;
		has_free    = tomb_seen_n || is_empty;
		finish      = hit || is_empty || last;
		next_idx    = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;

		unique case (state_q)
			S_IDLE:  rd_addr = q_job.home;
			S_PROBE: rd_addr = next_idx;
			default: rd_addr = idx_q;
		endcase

		kram_we          = 1'b0;
		kram_waddr       = idx_q;
		kram_wdata.state = SLOT_USED;
		kram_wdata.key   = job_q.key_id;
		vram_we          = 1'b0;
		vram_waddr       = idx_q;
		set_vld          = 1'b0;
		probe_status     = ST_MISSING;

		if (state_q == S_PROBE && finish) begin
			unique case (job_q.command)
				CMD_PUT: begin
					if (hit) begin
						vram_we      = 1'b1;
						probe_status = ST_OK;
					end else if (has_free) begin
						kram_we      = 1'b1;
						kram_waddr   = free_idx;
						vram_we      = 1'b1;
						vram_waddr   = free_idx;
						set_vld      = 1'b1;
						probe_status = ST_OK;
					end else begin
						probe_status = ST_FULL;
					end
				end
				CMD_DEL: begin
					if (hit) begin
						kram_we          = 1'b1;
						kram_wdata.state = SLOT_TOMB;
						probe_status     = ST_OK;
					end
				end
				default: begin
					probe_status = ST_MISSING;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			tomb_seen_q <= 1'b0;
			tomb_idx_q  <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (known_cmd) begin
							state_q     <= S_PROBE;
							idx_q       <= q_job.home;
							n_q         <= '0;
							tomb_seen_q <= 1'b0;
						end else begin
							res_q.status     <= ST_MISSING;
							res_q.read_value <= '0;
						end
					end
				end
				S_PROBE: begin
					if (finish) begin
						if (job_q.command == CMD_GET && hit) begin
							state_q <= S_GETV;
						end else begin
							state_q          <= S_IDLE;
							res_q.status     <= probe_status;
							res_q.read_value <= '0;
						end
					end else begin
						idx_q       <= next_idx;
						n_q         <= n_q + 1'b1;
						tomb_seen_q <= tomb_seen_n;
						tomb_idx_q  <= tomb_idx_n;
					end
				end
				S_GETV: begin
					state_q          <= S_IDLE;
					res_q.status     <= ST_OK;
					res_q.read_value <= vram_rdata;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A slot that was never written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (set_vld) begin
				vld_q[free_idx] <= 1'b1;
			end
			vld_rd_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= q_job;
		end
	end

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// ============================================================================
// Linear probe hash table
// Fixed-capacity key to value map with open addressing and linear probing.
// ============================================================================
// Each request item carries a command (get, put, delete), a 32-bit key
// identity, the key's precomputed 32-bit hash and a 64-bit value, and it
// produces exactly one result item with a status and a read value. Probing
// starts at hash modulo the slot count, wraps at the end of the table and
// stops at the matching key or at an empty slot; delete leaves a tombstone,
// and put updates a key in place or fills the first tombstone it passed, or
// else the empty slot that ended the probe, and reports full when neither
// exists. The front end takes an item and reduces its hash one byte per
// cycle; while busy, it takes a new item only as it hands the last one on
// to the queue. Classified items wait in a two-entry queue for the engine,
// which starts an item, probes the slots one at a time (the key store has
// one read port) and fetches the value in a further step on a successful
// get. The engine works on one item at a time, and the sustained rate is
// set by the slower of the two sides. Slot states are valid after reset at
// once: a flag for each slot marks it as written, so there is no clearing
// pass. The engine keeps a finished result in an output register while the
// front end keeps taking items, so either side may stall without the other
// losing work.
module linear_probe_hash_table
	import lph_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  logic pop,
	output res_t response
);

	logic job_push;
	logic job_full;
	job_t front_job;
	logic q_empty;
	logic q_pop;
	job_t q_job;

	// Front end: accept the item and work out its home slot.
	lph_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.job_push (job_push),
		.job_full (job_full),
		.job      (front_job)
	);

	// Queue that decouples the front end from the engine.
	lph_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.full   (job_full),
		.wdata  (front_job),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_job)
	);

	// Engine: probe the slot stores and deliver the result item.
	lph_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_job    (q_job),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

endmodule

// ===== rtl/lph_checker.sv =====
// ============================================================================
// Linear probe hash table checker
// Port-level assertions on the result side of the hash table.
// ============================================================================
module lph_checker
	import lph_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input req_t request,
	input logic empty,
	input logic pop,
	input res_t response
);

	// A waiting result item stays until it is taken.
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result item dropped before it was taken");

	// A waiting result item does not change.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(response))
		else $error("waiting result item changed");

	// Only a successful lookup returns a value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && response.status != ST_OK |-> response.read_value == 64'd0)
		else $error("nonzero read value on a failed request");

	// The status is always one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (response.status == ST_OK || response.status == ST_MISSING ||
			response.status == ST_FULL))
		else $error("undefined status code");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (.*);

// ===== tb/tb_linear_probe_hash_table.sv =====
// ============================================================================
// Linear probe hash table testbench
// Drives get, put, delete and unused request items through the queue-style
// input, predicts every result with a behavioral copy of the table and
// compares each result item field by field, under random idling on both sides.
// ============================================================================
module tb_linear_probe_hash_table
	import lph_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Command code 3 is not assigned; the block must leave the table alone.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Number of keys in the working set of a mixed phase.
	localparam int POOL = 12;
	// Number of distinct keys used to overfill the table.
	localparam int FILL = 70;
	// The sender pauses for a full drain when this many items have gone in.
	localparam int DRAIN_AT = 420;
	// The receiver holds off for a long stretch once this many results came.
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 400;
	// Wait after the last result; it covers a full probe of every slot, plus the queue.
	localparam int TAIL_CYCLES = 3 * SLOTS + 20;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	req_t request = '0;
	res_t response;

	linear_probe_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.empty(empty),
		.pop(pop),
		.response(response)
	);

	// Request items waiting to be offered, and results predicted for the
	// items that the block has already taken, oldest first.
	req_t request_q[$];
	res_t answer_q[$];

	// Shadow copy of the table. Slot keys and values are only read from
	// occupied slots, so their starting contents do not matter.
	logic [1:0]  tbl_state [SLOTS];
	logic [31:0] tbl_key [SLOTS];
	logic [63:0] tbl_val [SLOTS];

	// Working sets for the random phases.
	logic [31:0] pool_key [POOL];
	logic [31:0] pool_hash [POOL];
	logic [31:0] fill_key [FILL];
	logic [31:0] fill_hash [FILL];

	int errors = 0;
	int n_sent = 0;
	int n_got = 0;

	// Handshake bookkeeping shared between the rising-edge samplers and the
	// falling-edge drivers of each side.
	bit took = 1'b0;
	bit got = 1'b0;
	int send_gap = 0;
	int send_run = 0;
	int recv_gap = 0;
	int recv_run = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;

	res_t want;

	task automatic report(input string msg);
		errors++;
		$display("[%0t] ERROR: %s", $time, msg);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Most gaps are zero or short, a few are long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Applies one request to the shadow table and returns the result that
	// the block must give for it. The probe starts at the home slot, wraps,
	// visits every slot at most once and stops at the key or an empty slot.
	function automatic res_t table_apply(input req_t r);
		res_t res;
		int unsigned idx;
		int unsigned tomb_idx;
		int unsigned hit;
		int unsigned free_idx;
		bit tomb_seen;
		bit found;
		bit has_free;
		res.status = ST_MISSING;
		res.read_value = '0;
		if (r.command == CMD_GET || r.command == CMD_PUT || r.command == CMD_DEL) begin
			idx = r.key_hash % $unsigned(SLOTS);
			tomb_seen = 1'b0;
			found = 1'b0;
			has_free = 1'b0;
			tomb_idx = 0;
			hit = 0;
			free_idx = 0;
			for (int n = 0; n < SLOTS; n++) begin
				if (tbl_state[idx] == SLOT_EMPTY) begin
					// A tombstone passed earlier is preferred for a put.
					free_idx = tomb_seen ? tomb_idx : idx;
					has_free = 1'b1;
					break;
				end
				if (tbl_state[idx] == SLOT_USED) begin
					if (tbl_key[idx] == r.key_id) begin
						hit = idx;
						found = 1'b1;
						break;
					end
				end else if (!tomb_seen) begin
					// Tombstones, and the never-written code 3, are skipped.
					tomb_seen = 1'b1;
					tomb_idx = idx;
				end
				idx = (idx + 1) % $unsigned(SLOTS);
			end
			// A probe that went all the way round can only reuse a tombstone.
			if (!found && !has_free) begin
				has_free = tomb_seen;
				free_idx = tomb_idx;
			end
			case (r.command)
				CMD_GET: begin
					if (found) begin
						res.status = ST_OK;
						res.read_value = tbl_val[hit];
					end
				end
				CMD_PUT: begin
					if (found) begin
						tbl_val[hit] = r.value;
						res.status = ST_OK;
					end else if (has_free) begin
						tbl_state[free_idx] = SLOT_USED;
						tbl_key[free_idx] = r.key_id;
						tbl_val[free_idx] = r.value;
						res.status = ST_OK;
					end else begin
						res.status = ST_FULL;
					end
				end
				default: begin
					if (found) begin
						tbl_state[hit] = SLOT_TOMB;
						res.status = ST_OK;
					end
				end
			endcase
		end
		return res;
	endfunction

	task automatic queue_request(input logic [1:0] c, input logic [31:0] k, input logic [31:0] h,
			input logic [63:0] v);
		req_t r;
		r.command = c;
		r.key_id = k;
		r.key_hash = h;
		r.value = v;
		request_q.push_back(r);
	endtask

	// A fresh working set whose home slots crowd the two ends of the table,
	// so that probes collide and wrap; a few keys land anywhere.
	task automatic new_pool();
		int r;
		for (int i = 0; i < POOL; i++) begin
			pool_key[i] = $urandom();
			pool_hash[i] = $urandom();
			r = $urandom_range(0, 99);
			if (r < 40)
				pool_hash[i][IDX_W-1:0] = IDX_W'($urandom_range(0, 5));
			else if (r < 80)
				pool_hash[i][IDX_W-1:0] = IDX_W'($urandom_range(SLOTS - 6, SLOTS - 1));
		end
	endtask

	// Mostly well-formed traffic on the working set, with some unused
	// commands and some keys that come with a random hash.
	task automatic mixed_phase(input int count);
		int r;
		int p;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, POOL - 1);
			if (r < 35)
				queue_request(CMD_GET, pool_key[p], pool_hash[p], rand_word());
			else if (r < 70)
				queue_request(CMD_PUT, pool_key[p], pool_hash[p], rand_word());
			else if (r < 88)
				queue_request(CMD_DEL, pool_key[p], pool_hash[p], rand_word());
			else if (r < 93)
				queue_request(CMD_UNUSED, $urandom(), $urandom(), rand_word());
			else
				queue_request(2'($urandom_range(0, 2)), $urandom(), $urandom(), rand_word());
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset is held low at the start and released on a falling edge, away from the rising edge.
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#10_000_000;
		$display("linear_probe_hash_table: mismatch");
		$finish;
	end

	// Sender, rising edge: an item is taken when push is high and full low.
	// Its result is predicted right away, since results come back in order.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			answer_q.push_back(table_apply(request));
			void'(request_q.pop_front());
			n_sent++;
			took = 1'b1;
		end
	end

	// Sender, falling edge: an offered item is held until it is taken, then
	// the next one follows after a random gap. Once, the sender stops until
	// the block has handed back every result it owes.
	always @(negedge clk) begin
		if (arst_n && (!push || took)) begin
			took = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (request_q.size() != 0 && !(n_sent == DRAIN_AT && answer_q.size() != 0)) begin
				push <= 1'b1;
				request <= request_q[0];
				if (send_run > 0) begin
					send_run--;
					send_gap = 0;
				end else begin
					if ($urandom_range(0, 49) == 0)
						send_run = 40;
					send_gap = pick_gap();
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver, rising edge: each result taken is checked against the oldest
	// prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			got = 1'b1;
			n_got++;
			if (answer_q.size() == 0) begin
				report($sformatf("result status %0d value %h with no request waiting",
					response.status, response.read_value));
			end else begin
				want = answer_q.pop_front();
				if (response.status !== want.status)
					report($sformatf("result %0d: status %0d, predicted %0d",
						n_got, response.status, want.status));
				if (response.read_value !== want.read_value)
					report($sformatf("result %0d: read_value %h, predicted %h",
						n_got, response.read_value, want.read_value));
			end
		end
	end

	// Receiver, falling edge: pop is raised after random gaps. Once, the
	// receiver holds off for a long stretch so that the block fills up and
	// pushes back on the sender.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (!hold_done && n_got == HOLD_AT) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
				pop <= 1'b0;
			end else if (!pop || got) begin
				got = 1'b0;
				if (recv_gap > 0) begin
					recv_gap--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
					if (recv_run > 0) begin
						recv_run--;
						recv_gap = 0;
					end else begin
						if ($urandom_range(0, 49) == 0)
							recv_run = 40;
						recv_gap = pick_gap();
					end
				end
			end
		end
	end

	initial begin : stimulus
		int p;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = SLOT_EMPTY;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
		end

		// Directed part. Key zero goes to slot zero with a zero value, the
		// all-ones key to the last slot with an all-ones value.
		queue_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000, 64'h0);
		queue_request(CMD_GET, 32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		// This key shares the last slot as home, so it wraps past slot zero.
		queue_request(CMD_PUT, 32'h0000_1234, 32'h0000_003F, 64'h0123_4567_89AB_CDEF);
		queue_request(CMD_GET, 32'h0000_1234, 32'h0000_003F, 64'h0);
		queue_request(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		// Missing key: the probe runs into an empty slot.
		queue_request(CMD_GET, 32'h0000_5555, 32'h0000_0000, 64'h0);
		// Put on a present key updates it in place.
		queue_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hA5A5_5A5A_F00F_0FF0);
		queue_request(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		// Delete leaves a tombstone; deleting again finds nothing.
		queue_request(CMD_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(CMD_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
		// A lookup must probe past the tombstone.
		queue_request(CMD_GET, 32'h0000_1234, 32'h0000_003F, 64'h0);
		// A new key with that home reuses the tombstone.
		queue_request(CMD_PUT, 32'h0000_7777, 32'h0000_003F, 64'h8000_0000_0000_0001);
		queue_request(CMD_GET, 32'h0000_7777, 32'h0000_003F, 64'h0);
		// Unused command with every field at its top value changes nothing.
		queue_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(CMD_GET, 32'h0000_1234, 32'h0000_003F, 64'h0);
		// High hash bits play no part in the home slot.
		queue_request(CMD_PUT, 32'hAAAA_5555, 32'hFFFF_FFC0, 64'h5555_AAAA_3333_CCCC);
		queue_request(CMD_GET, 32'hAAAA_5555, 32'hFFFF_FFC0, 64'h0);
		queue_request(CMD_DEL, 32'h0000_0000, 32'h0000_0000, 64'h0);
		queue_request(CMD_DEL, 32'h0000_1234, 32'h0000_003F, 64'h0);
		queue_request(CMD_DEL, 32'h0000_7777, 32'h0000_003F, 64'h0);
		queue_request(CMD_DEL, 32'hAAAA_5555, 32'hFFFF_FFC0, 64'h0);

		// Random traffic on a small, colliding working set.
		new_pool();
		mixed_phase(300);

		// Overfill the table: the last puts must report it full, and lookups
		// of absent keys then probe every slot.
		for (int i = 0; i < FILL; i++) begin
			fill_key[i] = $urandom();
			fill_key[i][31:24] = 8'(8'hC0 + i);
			fill_hash[i] = $urandom();
			queue_request(CMD_PUT, fill_key[i], fill_hash[i], rand_word());
		end
		for (int i = 0; i < 40; i++) begin
			p = $urandom_range(0, 2);
			if (p == 0) begin
				p = $urandom_range(0, FILL - 1);
				queue_request(CMD_GET, fill_key[p], fill_hash[p], rand_word());
			end else if (p == 1) begin
				p = $urandom_range(0, POOL - 1);
				queue_request(CMD_GET, pool_key[p], pool_hash[p], rand_word());
			end else begin
				queue_request(CMD_GET, $urandom(), $urandom(), rand_word());
			end
		end
		queue_request(CMD_PUT, $urandom(), $urandom(), rand_word());
		queue_request(CMD_DEL, $urandom(), $urandom(), rand_word());
		// Open up to ten tombstones and refill them, with two puts more than that.
		for (int i = 0; i < 10; i++) begin
			p = $urandom_range(0, FILL - 1);
			queue_request(CMD_DEL, fill_key[p], fill_hash[p], rand_word());
		end
		for (int i = 0; i < 12; i++)
			queue_request(CMD_PUT, $urandom(), $urandom(), rand_word());
		// Empty the table again; it is left mostly tombstones.
		for (int i = 0; i < FILL; i++)
			queue_request(CMD_DEL, fill_key[i], fill_hash[i], rand_word());
		for (int i = 0; i < POOL; i++)
			queue_request(CMD_DEL, pool_key[i], pool_hash[i], rand_word());

		// Random traffic over a table full of tombstones.
		new_pool();
		mixed_phase(280);

		// Let every item go in and every result come back, then give the
		// block time to show any result it should not produce.
		while (request_q.size() != 0 || answer_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (answer_q.size() != 0)
			report($sformatf("%0d predicted results never came", answer_q.size()));
		if (errors == 0) begin
			$display("linear_probe_hash_table: match");
		end else begin
			$display("linear_probe_hash_table: mismatch");
		end
		$finish;
	end

endmodule
